// ===== hw/rtl/spa_pkg.sv =====
// spa_pkg: shared types, widths and codes for the sparse polynomial adder
// used by spa_ctrl, spa_dp and sparse_polynomial_adder_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

	localparam int EXP_W         = 16;
	localparam int COEF_W        = 24;
	localparam int SUM_W         = 32;
	localparam int MAX_TERMS_DEF = 32;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN  = 1'b1;
	localparam logic POLY_A    = 1'b0;
	localparam logic POLY_B    = 1'b1;

	typedef logic signed [EXP_W-1:0]  exp_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		logic  func;
		logic  which_poly;
		exp_t  exponent;
		coef_t coefficient;
	} in_item_t;

	typedef struct packed {
		exp_t out_exponent;
		sum_t out_coefficient;
		logic last_term;
		logic empty_sum;
		logic overflow;
	} out_item_t;

	typedef struct packed {
		exp_t  exponent;
		coef_t coefficient;
	} term_t;

	typedef struct packed {
		exp_t exponent;
		sum_t coefficient;
	} sum_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MRG_RD,
		ST_MRG_SEL,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_EMIT_RD,
		ST_EMIT_CHK
	} spa_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic run_init;
		logic take;
		logic append;
		logic update;
		logic next_k;
		logic scan_init;
		logic emit;
		logic emit_empty;
		logic clear_run;
	} spa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic a_left;
		logic b_left;
		logic srch_end;
		logic hit;
		logic nz_zero;
		logic emit_done;
		logic rd_nonzero;
	} spa_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spa_ctrl.sv =====
// spa_ctrl: sequencer for load, merge, table search and emission
// depends on spa_pkg; drives spa_dp through spa_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module spa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              func,
	input  wire spa_pkg::spa_stat_t stat,
	output spa_pkg::spa_cmd_t      cmd,
	output logic                   busy
);
	import spa_pkg::*;

	spa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (func == FUNC_RUN) begin
						cmd.run_init = 1'b1;
						state_d      = ST_MRG_RD;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_MRG_RD: begin
				if (!stat.a_left && !stat.b_left) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_EMIT_RD;
				end else begin
					state_d = ST_MRG_SEL;
				end
			end
			ST_MRG_SEL: begin
				cmd.take = 1'b1;
				state_d  = ST_SRCH_RD;
			end
			ST_SRCH_RD: begin
				if (stat.srch_end) begin
					cmd.append = 1'b1;
					state_d    = ST_MRG_RD;
				end else begin
					state_d = ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				if (stat.hit) begin
					cmd.update = 1'b1;
					state_d    = ST_MRG_RD;
				end else begin
					cmd.next_k = 1'b1;
					state_d    = ST_SRCH_RD;
				end
			end
			ST_EMIT_RD: begin
				if (stat.nz_zero) begin
					cmd.emit_empty = 1'b1;
					cmd.clear_run  = 1'b1;
					state_d        = ST_IDLE;
				end else if (stat.emit_done) begin
					cmd.clear_run = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_EMIT_CHK;
				end
			end
			ST_EMIT_CHK: begin
				cmd.next_k = 1'b1;
				cmd.emit   = stat.rd_nonzero;
				state_d    = ST_EMIT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/spa_dp.sv =====
// spa_dp: term lists, sum table, counters and result register
// depends on spa_pkg; commanded by spa_ctrl
`timescale 1ns / 1ps
`default_nettype none

module spa_dp #(
	parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spa_pkg::in_item_t item,
	input  wire spa_pkg::spa_cmd_t cmd,
	output spa_pkg::spa_stat_t     stat,
	output spa_pkg::out_item_t     result,
	output logic                   result_valid
);
	import spa_pkg::*;

	localparam int CW  = $clog2(MAX_TERMS + 1);
	localparam int AW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int SD  = 2 * MAX_TERMS;
	localparam int SAW = $clog2(SD);
	localparam int SCW = $clog2(SD + 1);

	term_t      a_mem [MAX_TERMS];
	term_t      b_mem [MAX_TERMS];
	sum_entry_t s_mem [SD];

	term_t      a_rd_q, b_rd_q, term_q;
	sum_entry_t s_rd_q;

	logic [CW-1:0]  a_cnt_q, b_cnt_q, i_q, j_q;
	logic [SCW-1:0] s_cnt_q, nz_q, k_q, emitted_q;
	logic           dropped_q;

	out_item_t result_q;
	logic      result_valid_q;

	logic       load_ok, a_full, b_full, a_we, b_we, s_we, pick_a;
	sum_entry_t s_wdata;
	logic [SAW-1:0] s_waddr;
	sum_t       term_ext, upd_sum;

	assign load_ok = cmd.load && (item.coefficient != '0);
	assign a_full  = (a_cnt_q == CW'(MAX_TERMS));
	assign b_full  = (b_cnt_q == CW'(MAX_TERMS));
	assign a_we    = load_ok && (item.which_poly == POLY_A) && !a_full;
	assign b_we    = load_ok && (item.which_poly == POLY_B) && !b_full;

	assign stat.a_left     = (i_q < a_cnt_q);
	assign stat.b_left     = (j_q < b_cnt_q);
	assign stat.srch_end   = (k_q == s_cnt_q);
	assign stat.hit        = (s_rd_q.exponent == term_q.exponent);
	assign stat.nz_zero    = (nz_q == '0);
	assign stat.emit_done  = (emitted_q == nz_q);
	assign stat.rd_nonzero = (s_rd_q.coefficient != '0);

	// A wins ties, and whichever list remains is drained
	assign pick_a = stat.a_left &&
		(!stat.b_left || ($signed(a_rd_q.exponent) <= $signed(b_rd_q.exponent)));

	assign term_ext = {{(SUM_W-COEF_W){term_q.coefficient[COEF_W-1]}}, term_q.coefficient};
	assign upd_sum  = s_rd_q.coefficient + term_ext;

	always_comb begin
		s_we    = cmd.append || cmd.update;
		s_waddr = cmd.append ? s_cnt_q[SAW-1:0] : k_q[SAW-1:0];
		s_wdata.exponent    = term_q.exponent;
		s_wdata.coefficient = cmd.append ? term_ext : upd_sum;
	end

	// memories
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[a_cnt_q[AW-1:0]] <= '{item.exponent, item.coefficient};
		end
		if (b_we) begin
			b_mem[b_cnt_q[AW-1:0]] <= '{item.exponent, item.coefficient};
		end
		if (s_we) begin
			s_mem[s_waddr] <= s_wdata;
		end
		a_rd_q <= a_mem[i_q[AW-1:0]];
		b_rd_q <= b_mem[j_q[AW-1:0]];
		s_rd_q <= s_mem[k_q[SAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			term_q <= pick_a ? a_rd_q : b_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q   <= '0;
			b_cnt_q   <= '0;
			i_q       <= '0;
			j_q       <= '0;
			s_cnt_q   <= '0;
			nz_q      <= '0;
			k_q       <= '0;
			emitted_q <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (a_we) begin
				a_cnt_q <= a_cnt_q + 1'b1;
			end
			if (b_we) begin
				b_cnt_q <= b_cnt_q + 1'b1;
			end
			if (load_ok && ((item.which_poly == POLY_A) ? a_full : b_full)) begin
				dropped_q <= 1'b1;
			end
			if (cmd.run_init) begin
				i_q     <= '0;
				j_q     <= '0;
				s_cnt_q <= '0;
				nz_q    <= '0;
			end
			if (cmd.take) begin
				k_q <= '0;
				if (pick_a) begin
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (cmd.append) begin
				s_cnt_q <= s_cnt_q + 1'b1;
				nz_q    <= nz_q + 1'b1;
			end
			// keep a running count of nonzero sums
			if (cmd.update) begin
				if ((s_rd_q.coefficient == '0) && (upd_sum != '0)) begin
					nz_q <= nz_q + 1'b1;
				end else if ((s_rd_q.coefficient != '0) && (upd_sum == '0)) begin
					nz_q <= nz_q - 1'b1;
				end
			end
			if (cmd.next_k) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.scan_init) begin
				k_q       <= '0;
				emitted_q <= '0;
			end
			if (cmd.emit) begin
				emitted_q <= emitted_q + 1'b1;
			end
			if (cmd.clear_run) begin
				a_cnt_q   <= '0;
				b_cnt_q   <= '0;
				i_q       <= '0;
				j_q       <= '0;
				s_cnt_q   <= '0;
				nz_q      <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	// result register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit || cmd.emit_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.out_exponent    <= s_rd_q.exponent;
			result_q.out_coefficient <= s_rd_q.coefficient;
			result_q.last_term       <= ((emitted_q + 1'b1) == nz_q);
			result_q.empty_sum       <= 1'b0;
			result_q.overflow        <= dropped_q;
		end else if (cmd.emit_empty) begin
			result_q.out_exponent    <= '0;
			result_q.out_coefficient <= '0;
			result_q.last_term       <= 1'b1;
			result_q.empty_sum       <= 1'b1;
			result_q.overflow        <= dropped_q;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

`ifndef SYNTHESIS
	a_nz_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		nz_q <= s_cnt_q)
		else $error("nonzero count exceeds sum table fill");

	a_sum_le_merged: assert property (@(posedge clk) disable iff (!arst_n)
		s_cnt_q <= (SCW'(i_q) + SCW'(j_q)))
		else $error("sum table holds more entries than merged terms");

	a_idx_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(i_q <= a_cnt_q) && (j_q <= b_cnt_q))
		else $error("merge index ran past its list");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.last_term) |=> !result_valid_q)
		else $error("result strobe after the last term");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_polynomial_adder_core.sv =====
// sparse_polynomial_adder_core: top level, spa_ctrl sequencer plus spa_dp datapath
// depends on spa_pkg, spa_ctrl, spa_dp
//
//   channel   ports                       transaction
//   input     start, busy, item           start && !busy at a rising edge
//   result    result_valid, result        one cycle per strobe, always taken
//
// a load does not raise busy; the next transaction may follow at once
// a run merges the lists, searching the sum table for each term's exponent to update a
// hit or append a new entry, then scans the table and emits its nonzero entries; the sum
// table's single read port sets the compare cost
// each result is registered and strobed for one cycle; busy drops with or after the last
// reset clears all counts, the drop flag, the result strobe and the state machine;
// list, table and result contents are not cleared, the fill counts bound every read
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_adder_core #(
	parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire spa_pkg::in_item_t item,
	output logic                   result_valid,
	output spa_pkg::out_item_t     result
);
	import spa_pkg::*;

	spa_cmd_t  cmd;
	spa_stat_t stat;

	spa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	spa_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking testbench for sparse_polynomial_adder_core, loads and runs with a scoreboard
// depends on spa_pkg and the sparse_polynomial_adder_core rtl
`timescale 1ns / 1ps

module tb;
	import spa_pkg::*;

	localparam int ITEM_TARGET = 460;
	localparam int IDLE_LIMIT  = 40000;
	localparam int TAIL_CYCLES = 40;
	localparam int LIST_DEPTH  = MAX_TERMS_DEF;
	localparam int SUM_DEPTH   = 2 * MAX_TERMS_DEF;

	typedef enum int {SEQ_PLAIN, SEQ_CANCEL, SEQ_OVERFLOW, SEQ_FULL, SEQ_NOISE} seq_kind_t;

	class spa_scoreboard;
		exp_t      a_exp[LIST_DEPTH];
		coef_t     a_coef[LIST_DEPTH];
		int        a_n;
		exp_t      b_exp[LIST_DEPTH];
		coef_t     b_coef[LIST_DEPTH];
		int        b_n;
		exp_t      sum_exp[SUM_DEPTH];
		sum_t      sum_coef[SUM_DEPTH];
		int        sum_n;
		bit        dropped;
		out_item_t expected_terms[$];
		int        errors;

		function new();
			a_n = 0;
			b_n = 0;
			sum_n = 0;
			dropped = 1'b0;
			errors = 0;
		endfunction

		// linear search in first-seen order, append on a new exponent
		function void fold_term(exp_t e, coef_t c);
			int k;
			for (k = 0; k < sum_n; k++) begin
				if (sum_exp[k] == e) begin
					sum_coef[k] = sum_coef[k] + sum_t'(c);
					return;
				end
			end
			sum_exp[sum_n] = e;
			sum_coef[sum_n] = sum_t'(c);
			sum_n++;
		endfunction

		function void add_polynomials();
			int        i;
			int        j;
			int        w;
			out_item_t r;
			sum_n = 0;
			i = 0;
			j = 0;
			// merge by exponent, a wins ties
			while (i < a_n || j < b_n) begin
				if (i < a_n && (j >= b_n || a_exp[i] <= b_exp[j])) begin
					fold_term(a_exp[i], a_coef[i]);
					i++;
				end else begin
					fold_term(b_exp[j], b_coef[j]);
					j++;
				end
			end
			w = 0;
			for (i = 0; i < sum_n; i++) begin
				if (sum_coef[i] != 0) begin
					sum_exp[w] = sum_exp[i];
					sum_coef[w] = sum_coef[i];
					w++;
				end
			end
			if (w == 0) begin
				r = '0;
				r.last_term = 1'b1;
				r.empty_sum = 1'b1;
				r.overflow = dropped;
				expected_terms.push_back(r);
			end else begin
				for (i = 0; i < w; i++) begin
					r.out_exponent = sum_exp[i];
					r.out_coefficient = sum_coef[i];
					r.last_term = (i == w - 1);
					r.empty_sum = 1'b0;
					r.overflow = dropped;
					expected_terms.push_back(r);
				end
			end
			a_n = 0;
			b_n = 0;
			sum_n = 0;
			dropped = 1'b0;
		endfunction

		function void note_item(in_item_t it);
			if (it.func == FUNC_RUN) begin
				add_polynomials();
				return;
			end
			if (it.coefficient == '0)
				return;
			if (it.which_poly == POLY_A) begin
				if (a_n < LIST_DEPTH) begin
					a_exp[a_n] = it.exponent;
					a_coef[a_n] = it.coefficient;
					a_n++;
				end else begin
					dropped = 1'b1;
				end
			end else begin
				if (b_n < LIST_DEPTH) begin
					b_exp[b_n] = it.exponent;
					b_coef[b_n] = it.coefficient;
					b_n++;
				end else begin
					dropped = 1'b1;
				end
			end
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_terms.size() == 0) begin
				report($sformatf("result with nothing expected: exp %0d coef %0d",
					got.out_exponent, got.out_coefficient));
				return;
			end
			want = expected_terms.pop_front();
			if (got.out_exponent !== want.out_exponent)
				report($sformatf("out_exponent %0d, expected %0d",
					got.out_exponent, want.out_exponent));
			if (got.out_coefficient !== want.out_coefficient)
				report($sformatf("out_coefficient %0d, expected %0d (exp %0d)",
					got.out_coefficient, want.out_coefficient, want.out_exponent));
			if (got.last_term !== want.last_term)
				report($sformatf("last_term %b, expected %b", got.last_term, want.last_term));
			if (got.empty_sum !== want.empty_sum)
				report($sformatf("empty_sum %b, expected %b", got.empty_sum, want.empty_sum));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_item_t  item = '0;
	logic      result_valid;
	out_item_t result;

	spa_scoreboard sb = new();
	int burst_left = 0;
	bit no_gaps = 1'b0;
	int items_sent = 0;
	int idle_cycles = 0;

	sparse_polynomial_adder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	always #1 clk = ~clk;

	// monitor: results first, then the accepted transaction, plus the idle watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(result);
			if (start && !busy) begin
				sb.note_item(item);
			end
			if (result_valid || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("** sparse_polynomial_adder_core: FAILED **");
				$finish;
			end
		end
	end

	task automatic drive(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic load_term(logic which, exp_t e, coef_t c);
		in_item_t it;
		it.func = FUNC_LOAD;
		it.which_poly = which;
		it.exponent = e;
		it.coefficient = c;
		drive(it);
	endtask

	// the other fields of a run are don't-care, so they get random values
	task automatic run_sum();
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.func = FUNC_RUN;
		drive(it);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_terms.size() != 0) @(posedge clk);
	endtask

	function automatic coef_t pick_coef();
		coef_t c;
		case ($urandom_range(0, 3))
			0: c = coef_t'(int'($urandom_range(1, 9)));
			1: c = -coef_t'(int'($urandom_range(1, 1000)));
			2: c = $urandom_range(0, 1) ? coef_t'(24'h7fffff) : coef_t'(24'h800000);
			default: c = coef_t'($urandom);
		endcase
		if (c == '0)
			c = coef_t'(1);
		return c;
	endfunction

	function automatic exp_t pick_exp(bit narrow);
		if (narrow)
			return exp_t'(int'($urandom_range(0, 12)) - 6);
		return exp_t'($urandom);
	endfunction

	initial begin
		seq_kind_t kind;
		int        seq_no;
		int        na;
		int        nb;
		int        n;
		int        k;
		int        idx;
		int        stride;
		int        offs;
		int        target;
		bit        narrow;
		exp_t      base;
		exp_t      ce[8];
		coef_t     cc[8];
		in_item_t  it;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty sum straight after reset
		run_sum();
		// field extremes on both lists, a zero-coefficient load in between
		load_term(POLY_A, exp_t'(16'h8000), coef_t'(24'h7fffff));
		load_term(POLY_A, exp_t'(16'h7fff), coef_t'(24'h800000));
		load_term(POLY_A, exp_t'(0), coef_t'(0));
		load_term(POLY_B, exp_t'(16'h8000), coef_t'(1));
		load_term(POLY_B, exp_t'(16'h7fff), coef_t'(24'h800000));
		load_term(POLY_B, exp_t'(16'hffff), coef_t'(24'hffffff));
		it = '1;
		drive(it);
		// unsorted loads, equal exponents across lists, one pair cancels
		load_term(POLY_A, exp_t'(3), coef_t'(5));
		load_term(POLY_A, exp_t'(1), coef_t'(2));
		load_term(POLY_B, exp_t'(3), coef_t'(-5));
		load_term(POLY_B, exp_t'(2), coef_t'(7));
		load_term(POLY_B, exp_t'(1), coef_t'(-1));
		run_sum();
		// everything cancels out
		load_term(POLY_A, exp_t'(9), coef_t'(24'h800000));
		load_term(POLY_B, exp_t'(9), coef_t'(24'h7fffff));
		load_term(POLY_B, exp_t'(9), coef_t'(1));
		run_sum();
		run_sum();
		wait_drained();

		seq_no = 0;
		while (items_sent < ITEM_TARGET) begin
			if (seq_no == 0)
				kind = SEQ_OVERFLOW;
			else if (seq_no == 1)
				kind = SEQ_FULL;
			else begin
				n = $urandom_range(0, 99);
				if (n < 60)
					kind = SEQ_PLAIN;
				else if (n < 76)
					kind = SEQ_CANCEL;
				else if (n < 82)
					kind = SEQ_OVERFLOW;
				else if (n < 85)
					kind = SEQ_FULL;
				else
					kind = SEQ_NOISE;
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			narrow = ($urandom_range(0, 2) != 0);

			case (kind)
				SEQ_PLAIN: begin
					na = $urandom_range(0, 8);
					nb = $urandom_range(0, 8);
					while (na > 0 || nb > 0) begin
						if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
							load_term(POLY_A, pick_exp(narrow),
								($urandom_range(0, 9) == 0) ? coef_t'(0) : pick_coef());
							na--;
						end else begin
							load_term(POLY_B, pick_exp(narrow),
								($urandom_range(0, 9) == 0) ? coef_t'(0) : pick_coef());
							nb--;
						end
					end
					run_sum();
				end
				SEQ_CANCEL: begin
					n = $urandom_range(1, 6);
					for (k = 0; k < n; k++) begin
						ce[k] = pick_exp(narrow);
						cc[k] = pick_coef();
						load_term(POLY_A, ce[k], cc[k]);
					end
					for (k = n - 1; k >= 0; k--)
						load_term(POLY_B, ce[k], -cc[k]);
					run_sum();
				end
				SEQ_OVERFLOW: begin
					target = $urandom_range(0, 2);
					if (target != 1)
						repeat (LIST_DEPTH + $urandom_range(1, 3))
							load_term(POLY_A, pick_exp(narrow), pick_coef());
					if (target != 0)
						repeat (LIST_DEPTH + $urandom_range(1, 3))
							load_term(POLY_B, pick_exp(narrow), pick_coef());
					// zero terms into a full list must not matter
					if ($urandom_range(0, 1))
						load_term(target == 1 ? POLY_B : POLY_A, pick_exp(narrow), coef_t'(0));
					run_sum();
				end
				SEQ_FULL: begin
					// odd stride walks all 64 slots once: even ones to a, odd ones to b
					base = exp_t'($urandom);
					stride = 2 * $urandom_range(0, 15) + 1;
					offs = $urandom_range(0, SUM_DEPTH - 1);
					for (k = 0; k < SUM_DEPTH; k++) begin
						idx = (offs + k * stride) % SUM_DEPTH;
						load_term(idx[0] ? POLY_B : POLY_A, base + exp_t'(idx), pick_coef());
					end
					run_sum();
				end
				default: begin
					n = $urandom_range(1, 10);
					repeat (n) begin
						it = in_item_t'({$urandom, $urandom});
						it.func = ($urandom_range(0, 4) == 0) ? FUNC_RUN : FUNC_LOAD;
						drive(it);
					end
				end
			endcase

			if ($urandom_range(0, 7) == 0)
				wait_drained();
			seq_no++;
		end
		run_sum();

		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_terms.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.expected_terms.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_terms.size()));

		if (sb.errors == 0) begin
			$display("** sparse_polynomial_adder_core: PASSED **");
		end else begin
			$display("** sparse_polynomial_adder_core: FAILED **");
		end
		$finish;
	end

endmodule
